[src/ecft_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecft_pkg
// Shared types and constants of the escaped CRC frame transmitter.
// ---------------------------------------------------------------------------
package ecft_pkg;

   // Line bytes and CRC polynomial
   localparam logic [7:0]  FRAME_MARK = 8'hFF;
   localparam logic [7:0]  ESC_BYTE   = 8'h1B;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   // Request transaction kinds
   localparam logic [1:0] REQ_CMD = 2'd0;
   localparam logic [1:0] REQ_HDR = 2'd1;
   localparam logic [1:0] REQ_PAY = 2'd2;

   // Job kinds handed from the front end to the serializer
   localparam logic [1:0] JOB_CMD = 2'd0;
   localparam logic [1:0] JOB_HDR = 2'd1;
   localparam logic [1:0] JOB_PAY = 2'd2;

   // Number of jobs held between front end and serializer
   localparam int QUEUE_DEPTH = 4;

   // One job: everything the serializer needs to emit its bytes
   typedef struct packed {
      logic [1:0]  kind;    // JOB_CMD, JOB_HDR or JOB_PAY
      logic [7:0]  code;    // command code, or raw payload byte
      logic [15:0] length;  // frame length of a header
      logic [15:0] crc;     // CRC to send when the frame closes
      logic        close;   // append CRC trailer and closing mark
   } job_type;

endpackage

[src/ecft_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecft_front
// Accepts request transactions, tracks the open data frame and its CRC,
// and pushes one job per transaction that produces line bytes.
// ---------------------------------------------------------------------------
module ecft_front
   import ecft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_frame_cmd,
   input  logic [15:0] req_frame_length,
   input  logic [7:0]  req_payload_byte,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   // Header CRC phases: length bytes enter CRC one per cycle if not full
   localparam logic [1:0] HP_IDLE = 2'd0;
   localparam logic [1:0] HP_HI   = 2'd1;
   localparam logic [1:0] HP_LO   = 2'd2;

   logic [1:0]  hp_ff, hp_in;
   logic        frame_open_ff, frame_open_in;
   logic [15:0] remain_ff, remain_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic        accept;

   // Advance a CRC-16 by one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   assign req_stall = (hp_ff != HP_IDLE) || q_full;
   assign accept    = req_valid && !req_stall;

   // Classify the transaction and update frame state
   always_comb begin
      logic [15:0] crc_new;
      logic [15:0] rem_dec;
      hp_in         = hp_ff;
      frame_open_in = frame_open_ff;
      remain_in     = remain_ff;
      crc_in        = crc_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      q_push        = 1'b0;
      q_job         = '0;
      crc_new       = crc_byte(crc_ff, req_payload_byte);
      rem_dec       = remain_ff - 16'd1;
      unique case (hp_ff)
         HP_HI: begin
            crc_in = crc_byte(crc_ff, len_ff[15:8]);
            hp_in  = HP_LO;
         end
         HP_LO: begin
            crc_new = crc_byte(crc_ff, len_ff[7:0]);
            if (!q_full) begin
               q_push       = 1'b1;
               q_job.kind   = JOB_HDR;
               q_job.code   = cmd_ff;
               q_job.length = len_ff;
               q_job.crc    = crc_new;
               q_job.close  = (len_ff == 16'd0);
               crc_in       = crc_new;
               hp_in        = HP_IDLE;
               if (len_ff == 16'd0) begin
                  frame_open_in = 1'b0;
               end
            end
         end
         HP_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_CMD: begin
                     q_push     = 1'b1;
                     q_job.kind = JOB_CMD;
                     q_job.code = req_frame_cmd;
                  end
                  REQ_HDR: begin
                     // Open a new frame, dropping any open one
                     cmd_in        = req_frame_cmd;
                     len_in        = req_frame_length;
                     crc_in        = crc_byte(16'h0000, req_frame_cmd);
                     frame_open_in = 1'b1;
                     remain_in     = req_frame_length;
                     hp_in         = HP_HI;
                  end
                  REQ_PAY: begin
                     if (frame_open_ff) begin
                        q_push      = 1'b1;
                        q_job.kind  = JOB_PAY;
                        q_job.code  = req_payload_byte;
                        q_job.crc   = crc_new;
                        q_job.close = (rem_dec == 16'd0);
                        crc_in      = crc_new;
                        remain_in   = rem_dec;
                        if (rem_dec == 16'd0) begin
                           frame_open_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     // drop unused transaction kind
                  end
               endcase
            end
         end
         default: begin
            hp_in = HP_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff         <= HP_IDLE;
         frame_open_ff <= 1'b0;
         remain_ff     <= 16'd0;
         crc_ff        <= 16'd0;
      end else begin
         hp_ff         <= hp_in;
         frame_open_ff <= frame_open_in;
         remain_ff     <= remain_in;
         crc_ff        <= crc_in;
      end
   end

   // Held header fields
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      len_ff <= len_in;
   end

endmodule

[src/ecft_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecft_queue
// Small job queue that decouples the front end from the serializer.
// ---------------------------------------------------------------------------
module ecft_queue
   import ecft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   job_type               entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full       = (count_ff == CntWidth'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[src/ecft_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecft_back
// Serializer: walks the symbols of the head job, inserts escape bytes and
// drives the registered response channel, one byte per cycle while not stalled.
// ---------------------------------------------------------------------------
module ecft_back
   import ecft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   logic [2:0] idx_ff, idx_in;
   logic       esc_done_ff, esc_done_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       fend_ff, fend_in;

   logic [7:0] sym_byte;
   logic       sym_esc;
   logic       sym_end;
   logic [2:0] last_idx;
   logic       load_ok;
   logic       advance;
   logic       need_esc;
   logic       sym_last;

   // Decode the current symbol of the head job
   always_comb begin
      sym_byte = FRAME_MARK;
      sym_esc  = 1'b0;
      sym_end  = 1'b0;
      last_idx = 3'd0;
      unique case (head_job.kind)
         JOB_CMD: begin
            last_idx = 3'd2;
            unique case (idx_ff)
               3'd0: sym_byte = FRAME_MARK;
               3'd1: sym_byte = head_job.code;
               default: begin
                  sym_byte = FRAME_MARK;
                  sym_end  = 1'b1;
               end
            endcase
         end
         JOB_HDR: begin
            last_idx = head_job.close ? 3'd6 : 3'd3;
            unique case (idx_ff)
               3'd0: sym_byte = FRAME_MARK;
               3'd1: sym_byte = head_job.code;
               3'd2: sym_byte = head_job.length[15:8];
               3'd3: sym_byte = head_job.length[7:0];
               3'd4: begin
                  sym_byte = head_job.crc[15:8];
                  sym_esc  = 1'b1;
               end
               3'd5: begin
                  sym_byte = head_job.crc[7:0];
                  sym_esc  = 1'b1;
               end
               default: begin
                  sym_byte = FRAME_MARK;
                  sym_end  = 1'b1;
               end
            endcase
         end
         default: begin
            // payload job
            last_idx = head_job.close ? 3'd3 : 3'd0;
            unique case (idx_ff)
               3'd0: begin
                  sym_byte = head_job.code;
                  sym_esc  = 1'b1;
               end
               3'd1: begin
                  sym_byte = head_job.crc[15:8];
                  sym_esc  = 1'b1;
               end
               3'd2: begin
                  sym_byte = head_job.crc[7:0];
                  sym_esc  = 1'b1;
               end
               default: begin
                  sym_byte = FRAME_MARK;
                  sym_end  = 1'b1;
               end
            endcase
         end
      endcase
   end

   assign load_ok  = !valid_ff || !rsp_stall;
   assign advance  = head_valid && load_ok;
   assign need_esc = sym_esc && !esc_done_ff &&
                     ((sym_byte == FRAME_MARK) || (sym_byte == ESC_BYTE));
   assign sym_last = (idx_ff == last_idx);
   assign pop      = advance && !need_esc && sym_last;

   // Emit an escape or the symbol byte, then advance the symbol index
   always_comb begin
      idx_in      = idx_ff;
      esc_done_in = esc_done_ff;
      valid_in    = valid_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      fend_in     = fend_ff;
      if (load_ok) begin
         valid_in = head_valid;
      end
      if (advance) begin
         if (need_esc) begin
            byte_in     = ESC_BYTE;
            last_in     = 1'b0;
            fend_in     = 1'b0;
            esc_done_in = 1'b1;
         end else begin
            byte_in     = sym_byte;
            last_in     = sym_last;
            fend_in     = sym_end;
            esc_done_in = 1'b0;
            idx_in      = sym_last ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= 3'd0;
         esc_done_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         esc_done_ff <= esc_done_in;
         valid_ff    <= valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      fend_ff <= fend_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_run_last  = last_ff;
   assign rsp_frame_end = fend_ff;

endmodule

[src/escaped_crc_frame_transmitter_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// escaped_crc_frame_transmitter_core
// Byte-stuffing frame transmitter with CRC-16 (poly 0x1021, init 0) trailer.
// ---------------------------------------------------------------------------
// The serializer sends one line byte per cycle while rsp_stall is low. Line
// bytes produced per transaction: a command 3, a payload byte 1
// or 2 (escaped), plus 3 to 5 more when it closes the frame with the CRC and
// closing mark, and a header 4, plus 3 to 5 more with an empty frame. A
// header also keeps the request side busy (req_stall high after it is taken
// until its job is pushed) while its command and length bytes enter the CRC
// one per cycle unless the queue is full. A queue of QUEUE_DEPTH jobs sits
// between the request front end and the serializer, so requests keep being
// taken while the response side is stalled until that queue fills.
// ---------------------------------------------------------------------------
module escaped_crc_frame_transmitter_core
   import ecft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_frame_cmd,
   input  logic [15:0] req_frame_length,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_frame_end
);

   logic    q_full;
   logic    q_push;
   job_type q_job;
   logic    q_pop;
   logic    head_valid;
   job_type head_job;

   // Accept and classify transactions
   ecft_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_frame_cmd    (req_frame_cmd),
      .req_frame_length (req_frame_length),
      .req_payload_byte (req_payload_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (q_job)
   );

   // Hold jobs between the two sides
   ecft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Serialize jobs onto the line
   ecft_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
